@@ src/fvn_pkg.sv @@
// Shared constants for the fractal value-noise height pipeline.
package fvn_pkg;

    localparam int Octaves = 4;

    // Octave frequencies, unsigned Q0.24, rounded to nearest.
    localparam logic [21:0] FREQ_Q24 [Octaves] = '{
        22'd201327, 22'd503316, 22'd1207960, 22'd3019899
    };
    // Octave weights in tenths.
    localparam logic [6:0] WEIGHT_TENTHS [Octaves] = '{7'd80, 7'd30, 7'd10, 7'd3};

    localparam logic [31:0] PRIME_X = 32'd73856093;
    localparam logic [31:0] PRIME_Z = 32'd19349663;
    localparam logic [30:0] MASK31  = 31'h7FFFFFFF;

    // floor(2^44 / 10000): quotient estimate is exact or one low.
    localparam logic [30:0] RECIP_MOD = 31'd1759218604;
    localparam logic [13:0] NOISE_MOD = 14'd10000;

    // floor(2^40 / 3125): final scaling divide, exact or one low.
    localparam logic [28:0] RECIP_SCALE = 29'd351843720;
    localparam logic [11:0] SCALE_DIV   = 12'd3125;
    localparam logic [16:0] ROUND_HALF  = 17'd50000;
    localparam logic [16:0] HEIGHT_OFS  = 17'd20480;

endpackage

@@ src/fvn_corner.sv @@
// Lattice corner hash and modulo-10000 reduction, four register stages.
module fvn_corner (
    input  logic        i_clk,
    input  logic [31:0] i_cx,
    input  logic [31:0] i_cz,
    output logic [13:0] o_value
);
    logic [31:0] r_hx, r_hz;
    logic [30:0] h;
    logic [61:0] hm;
    logic [30:0] r_h;
    logic [17:0] r_q;
    logic [31:0] qm;
    logic [31:0] diff;
    logic [14:0] r_rp;
    logic [13:0] r_val;

    assign h    = (r_hx[30:0] ^ r_hz[30:0]) & fvn_pkg::MASK31;
    assign hm   = 62'(h) * 62'(fvn_pkg::RECIP_MOD);
    assign qm   = 32'(r_q) * 32'(fvn_pkg::NOISE_MOD);
    assign diff = 32'(r_h) - qm;

    always_ff @(posedge i_clk) begin
        r_hx  <= i_cx * fvn_pkg::PRIME_X;
        r_hz  <= i_cz * fvn_pkg::PRIME_Z;
        r_h   <= h;
        r_q   <= hm[61:44];
        r_rp  <= diff[14:0];
        // fold the one-low quotient estimate
        r_val <= (r_rp >= 15'(fvn_pkg::NOISE_MOD)) ? 14'(r_rp - 15'(fvn_pkg::NOISE_MOD))
                                                   : r_rp[13:0];
    end

    assign o_value = r_val;
endmodule

@@ src/fvn_octave.sv @@
// One noise octave: scale, smoothstep, corner hashes, bilinear blend, weight.
module fvn_octave (
    input  logic               i_clk,
    input  logic signed [23:0] i_x,
    input  logic signed [23:0] i_z,
    input  logic        [21:0] i_freq,
    input  logic        [6:0]  i_weight,
    output logic        [52:0] o_wv
);
    logic signed [46:0] r_px, r_pz;
    logic [31:0] cx, cz, cx1, cz1;
    logic [15:0] r_tx, r_tz;
    logic [31:0] r_tx2, r_tz2;
    logic [17:0] fx, fz;
    logic [49:0] spx, spz;
    logic [16:0] r_sx3, r_sx4, r_sx5, r_sz3, r_sz4, r_sz5, r_sz6;
    logic [13:0] va, vb, vc, vd;
    logic signed [14:0] dba, ddc;
    logic signed [32:0] pba, pdc;
    logic signed [33:0] ash, csh;
    logic signed [33:0] r_lo, r_hi;
    logic signed [34:0] dhl;
    logic signed [52:0] phl, vs;
    logic [45:0] r_v;
    logic [52:0] r_wv;

    assign cx  = {{18{r_px[45]}}, r_px[45:32]};
    assign cz  = {{18{r_pz[45]}}, r_pz[45:32]};
    assign cx1 = cx + 32'd1;
    assign cz1 = cz + 32'd1;

    fvn_corner u_a (.i_clk(i_clk), .i_cx(cx),  .i_cz(cz),  .o_value(va));
    fvn_corner u_b (.i_clk(i_clk), .i_cx(cx1), .i_cz(cz),  .o_value(vb));
    fvn_corner u_c (.i_clk(i_clk), .i_cx(cx),  .i_cz(cz1), .o_value(vc));
    fvn_corner u_d (.i_clk(i_clk), .i_cx(cx1), .i_cz(cz1), .o_value(vd));

    assign fx  = 18'd196608 - {1'b0, r_tx, 1'b0};
    assign fz  = 18'd196608 - {1'b0, r_tz, 1'b0};
    assign spx = 50'(r_tx2) * 50'(fx);
    assign spz = 50'(r_tz2) * 50'(fz);

    assign dba = $signed({1'b0, vb}) - $signed({1'b0, va});
    assign ddc = $signed({1'b0, vd}) - $signed({1'b0, vc});
    assign pba = dba * $signed({1'b0, r_sx5});
    assign pdc = ddc * $signed({1'b0, r_sx5});
    assign ash = $signed({4'b0, va, 16'b0});
    assign csh = $signed({4'b0, vc, 16'b0});

    assign dhl = $signed({r_hi[33], r_hi}) - $signed({r_lo[33], r_lo});
    assign phl = dhl * $signed({1'b0, r_sz6});
    assign vs  = $signed({{3{r_lo[33]}}, r_lo, 16'b0}) + phl;

    always_ff @(posedge i_clk) begin
        r_px  <= i_x * $signed({1'b0, i_freq});
        r_pz  <= i_z * $signed({1'b0, i_freq});
        r_tx  <= r_px[31:16];
        r_tz  <= r_pz[31:16];
        r_tx2 <= 32'(r_px[31:16]) * 32'(r_px[31:16]);
        r_tz2 <= 32'(r_pz[31:16]) * 32'(r_pz[31:16]);
        r_sx3 <= spx[48:32];
        r_sz3 <= spz[48:32];
        r_sx4 <= r_sx3;
        r_sz4 <= r_sz3;
        r_sx5 <= r_sx4;
        r_sz5 <= r_sz4;
        r_sz6 <= r_sz5;
        r_lo  <= ash + {pba[32], pba};
        r_hi  <= csh + {pdc[32], pdc};
        r_v   <= vs[45:0];
        r_wv  <= 53'(r_v) * 53'(i_weight);
    end

    assign o_wv = r_wv;
endmodule

@@ src/fvn_combine.sv @@
// Octave sum, rounded scaling to Q.12 by reciprocal divide, offset removal.
module fvn_combine (
    input  logic                        i_clk,
    input  logic [fvn_pkg::Octaves-1:0][52:0] i_wv,
    output logic signed [15:0]          o_height
);
    logic [54:0] sum;
    logic [33:0] y;
    logic [27:0] r_y5, r_y5b;
    logic [56:0] qp;
    logic [16:0] r_qe;
    logic [28:0] qm, rem;
    logic        corr;
    logic [15:0] r_h;

    always_comb begin
        sum = '0;
        for (int i = 0; i < fvn_pkg::Octaves; i++) begin
            sum = sum + 55'(i_wv[i]);
        end
    end

    assign y    = sum[53:20] + 34'(fvn_pkg::ROUND_HALF);
    assign qp   = 57'(r_y5) * 57'(fvn_pkg::RECIP_SCALE);
    assign qm   = 29'(r_qe) * 29'(fvn_pkg::SCALE_DIV);
    assign rem  = {1'b0, r_y5b} - qm;
    assign corr = rem >= 29'(fvn_pkg::SCALE_DIV);

    always_ff @(posedge i_clk) begin
        r_y5  <= y[32:5];
        r_y5b <= r_y5;
        r_qe  <= qp[56:40];
        r_h   <= 16'(r_qe + 17'(corr) - fvn_pkg::HEIGHT_OFS);
    end

    assign o_height = $signed(r_h);
endmodule

@@ src/fractal_value_noise_height_unit.sv @@
// Top level of the four-octave value-noise terrain height pipeline.
// One coordinate transfer may be issued on every clock: busy never rises, and
// o_valid rises when the pair's marker leaves the r_vld shift register, in step
// with the height. o_valid is high for one cycle.
// The receiver cannot stall, so take each result when o_valid is high.
// Pipeline depth is eight stages per octave lane
// (coordinate scale, corner hash, modulo estimate, remainder, modulo fix,
// two interpolation stages, weighting) and three for the summed reciprocal
// divide. Results leave in the order the pairs came in.
module fractal_value_noise_height_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic signed [23:0] i_x_coord,
    input  logic signed [23:0] i_z_coord,
    output logic               busy,
    output logic               o_valid,
    output logic signed [15:0] o_height
);
    localparam int Latency = 11;

    logic [fvn_pkg::Octaves-1:0][52:0] wv;
    logic [Latency-1:0] r_vld;
    logic [Latency-1:0] n_vld;

    // four octave lanes in parallel, each with its own frequency and weight
    for (genvar g = 0; g < fvn_pkg::Octaves; g++) begin : g_oct
        fvn_octave u_oct (
            .i_clk    (i_clk),
            .i_x      (i_x_coord),
            .i_z      (i_z_coord),
            .i_freq   (fvn_pkg::FREQ_Q24[g]),
            .i_weight (fvn_pkg::WEIGHT_TENTHS[g]),
            .o_wv     (wv[g])
        );
    end

    fvn_combine u_comb (
        .i_clk    (i_clk),
        .i_wv     (wv),
        .o_height (o_height)
    );

    // advance the valid marker alongside the data
    assign n_vld = {r_vld[Latency-2:0], start};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign busy    = 1'b0;
    assign o_valid = r_vld[Latency-1];

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##11 o_valid)
        else $error("result strobe missing after transfer");
    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 11))
        else $error("result strobe without a transfer");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_height >= -16'sd20480) && (o_height <= 16'sd29901))
        else $error("height out of range");
`endif
endmodule
